/* sv/cil_pkg.sv */
package cil_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 23;
    localparam int OUT_ADDR_BITS = 23;

    typedef struct packed {
        logic       end_of_file;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [22:0] address;
        logic [7:0]  data;
        logic [4:0]  cart_code;
        logic [2:0]  status;
    } out_word_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_CHIP   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_STOP   = 5'b10000
    } phase_t;

    localparam logic [4:0] CL_NONE       = 5'd0;
    localparam logic [4:0] CL_NORMAL     = 5'd1;
    localparam logic [4:0] CL_ACTION     = 5'd2;
    localparam logic [4:0] CL_RETRO      = 5'd3;
    localparam logic [4:0] CL_DOMARK     = 5'd4;
    localparam logic [4:0] CL_OCEAN      = 5'd5;
    localparam logic [4:0] CL_EASYFLASH  = 5'd6;
    localparam logic [4:0] CL_SUPERSNAP  = 5'd7;
    localparam logic [4:0] CL_EPYX       = 5'd8;
    localparam logic [4:0] CL_FINAL3     = 5'd9;
    localparam logic [4:0] CL_SYSTEM3    = 5'd10;
    localparam logic [4:0] CL_COMAL80    = 5'd11;
    localparam logic [4:0] CL_SBASIC     = 5'd12;
    localparam logic [4:0] CL_WESTERMANN = 5'd13;
    localparam logic [4:0] CL_KCS        = 5'd14;
    localparam logic [4:0] CL_FINAL12    = 5'd15;
    localparam logic [4:0] CL_BBASIC     = 5'd16;
    localparam logic [4:0] CL_NI         = 5'd31;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIG  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_NOT_IMPL = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;

    function automatic logic [7:0] sig_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:  c = 8'h43;
            4'd1:  c = 8'h36;
            4'd2:  c = 8'h34;
            4'd4:  c = 8'h43;
            4'd5:  c = 8'h41;
            4'd6:  c = 8'h52;
            4'd7:  c = 8'h54;
            4'd8:  c = 8'h52;
            4'd9:  c = 8'h49;
            4'd10: c = 8'h44;
            4'd11: c = 8'h47;
            4'd12: c = 8'h45;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tag_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0: c = 8'h43;
            2'd1: c = 8'h48;
            2'd2: c = 8'h49;
            default: c = 8'h50;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] type_class(input logic [7:0] t);
        logic [4:0] c;
        case (t)
            8'd0:  c = CL_NORMAL;
            8'd1:  c = CL_ACTION;
            8'd2:  c = CL_KCS;
            8'd3:  c = CL_FINAL3;
            8'd4:  c = CL_SBASIC;
            8'd5:  c = CL_OCEAN;
            8'd9:  c = CL_RETRO;
            8'd10: c = CL_EPYX;
            8'd11: c = CL_WESTERMANN;
            8'd13: c = CL_FINAL12;
            8'd15: c = CL_SYSTEM3;
            8'd19: c = CL_DOMARK;
            8'd20: c = CL_SUPERSNAP;
            8'd21: c = CL_COMAL80;
            8'd32: c = CL_EASYFLASH;
            8'd36: c = CL_RETRO;
            8'd54: c = CL_BBASIC;
            default:
            begin
                if ((t >= 8'd22 && t <= 8'd31) || t >= 8'd61)
                    c = CL_NONE;
                else
                    c = CL_NI;
            end
        endcase
        return c;
    endfunction

    function automatic logic split_class(input logic [4:0] c);
        return c == CL_OCEAN || c == CL_EASYFLASH || c == CL_DOMARK || c == CL_SYSTEM3;
    endfunction

endpackage

/* sv/cil_summary.sv */
module cil_summary (
    input  logic [4:0]  loader_class,
    input  logic [7:0]  exrom_byte,
    input  logic [7:0]  game_byte,
    input  logic [23:0] total_loaded,
    input  logic        upper_range_seen,
    output logic [4:0]  cart_code
);

    always_comb
    begin
        cart_code = 5'd0;
        if (total_loaded != 24'd0)
        begin
            case (loader_class)
                cil_pkg::CL_NORMAL:
                begin
                    if (exrom_byte == 8'd0 && game_byte == 8'd1)
                        cart_code = 5'h03;
                    else if (exrom_byte == 8'd1 && game_byte == 8'd1)
                        cart_code = 5'h02;
                    else if (exrom_byte == 8'd1 && game_byte == 8'd0)
                        cart_code = 5'h01;
                    else
                        cart_code = (total_loaded > 24'd8192) ? 5'h02 : 5'h01;
                end
                cil_pkg::CL_ACTION:     cart_code = 5'h07;
                cil_pkg::CL_RETRO:      cart_code = 5'h06;
                cil_pkg::CL_DOMARK:     cart_code = 5'h09;
                cil_pkg::CL_OCEAN:      cart_code = upper_range_seen ? 5'h0B : 5'h0A;
                cil_pkg::CL_EASYFLASH:  cart_code = 5'h0C;
                cil_pkg::CL_SUPERSNAP:  cart_code = 5'h05;
                cil_pkg::CL_EPYX:       cart_code = 5'h0E;
                cil_pkg::CL_FINAL3:     cart_code = 5'h04;
                cil_pkg::CL_SYSTEM3:    cart_code = 5'h08;
                cil_pkg::CL_COMAL80:    cart_code = 5'h0F;
                cil_pkg::CL_SBASIC:     cart_code = 5'h10;
                cil_pkg::CL_WESTERMANN: cart_code = 5'h11;
                cil_pkg::CL_KCS:        cart_code = 5'h13;
                cil_pkg::CL_FINAL12:    cart_code = 5'h14;
                cil_pkg::CL_BBASIC:     cart_code = 5'h15;
                default:                cart_code = 5'd0;
            endcase
        end
    end

endmodule

/* sv/cil_parser.sv */
module cil_parser #(
    parameter int ADDRESS_BITS = cil_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cil_pkg::in_word_t   in_word,
    output logic                emit,
    output cil_pkg::out_word_t  out_word
);

    localparam int OUT_ADDR = cil_pkg::OUT_ADDR_BITS;
    localparam logic [ADDRESS_BITS-1:0] HALF_MEG = ADDRESS_BITS'(512 * 1024);
    localparam logic [ADDRESS_BITS-1:0] SPLIT_STEP = ADDRESS_BITS'(512 * 1024 - 8192);
    localparam logic [ADDRESS_BITS-1:0] KCS_BASE = ADDRESS_BITS'(32'h8000);

    cil_pkg::phase_t         phase_reg, phase_next;
    logic [31:0]             pos_reg, pos_next;
    logic [31:0]             hlen_reg, hlen_next;
    logic [4:0]              class_reg, class_next;
    logic [7:0]              exrom_reg, exrom_next;
    logic [7:0]              game_reg, game_next;
    logic [3:0]              idx_reg, idx_next;
    logic [15:0]             bank_reg, bank_next;
    logic [15:0]             load_reg, load_next;
    logic [15:0]             size_reg, size_next;
    logic [15:0]             left_reg, left_next;
    logic [ADDRESS_BITS-1:0] waddr_reg, waddr_next;
    logic [23:0]             total_reg, total_next;
    logic                    upper_reg, upper_next;
    logic [2:0]              stop_reg, stop_next;

    logic [7:0]  b;
    logic [4:0]  tclass;
    logic [4:0]  code;
    logic [15:0] done;
    logic [15:0] bank_fix;
    logic [31:0] hlen_fix;
    logic        split_now;
    logic [21:0] plain_base;
    logic [ADDRESS_BITS-1:0] base_addr;
    logic [2:0]  end_st;

    assign b = in_word.data_byte;
    assign tclass = cil_pkg::type_class(b);
    assign done = size_reg - left_reg;
    assign split_now = cil_pkg::split_class(class_reg) && size_reg > 16'h2000;

    cil_summary u_summary (
        .loader_class     (class_reg),
        .exrom_byte       (exrom_reg),
        .game_byte        (game_reg),
        .total_loaded     (total_reg),
        .upper_range_seen (upper_reg),
        .cart_code        (code)
    );

    // The size byte completing a chip header is b, so the packet fields are assembled here.
    logic [15:0] size_full;
    assign size_full = {size_reg[7:0], b};

    always_comb
    begin
        bank_fix = bank_reg;
        if (class_reg == cil_pkg::CL_OCEAN && load_reg == 16'hA000)
            bank_fix = bank_reg & 16'h00EF;
        plain_base = {6'd0, size_full} * {16'd0, bank_fix[5:0]};
        if (cil_pkg::split_class(class_reg) && size_full > 16'h2000)
            base_addr = ADDRESS_BITS'({bank_fix[5:0], 13'd0});
        else
            base_addr = ADDRESS_BITS'(plain_base);
        if (load_reg == 16'hA000)
            base_addr = base_addr + HALF_MEG;
        if (class_reg == cil_pkg::CL_KCS)
            base_addr = ADDRESS_BITS'(load_reg) - KCS_BASE;
    end

    always_comb
    begin
        hlen_fix = (class_reg == cil_pkg::CL_KCS) ? 32'h40 : hlen_reg;
        if (hlen_fix < 32'h20)
            hlen_fix = 32'h20;
    end

    always_comb
    begin
        case (phase_reg)
            cil_pkg::PH_HEADER: end_st = cil_pkg::ST_BAD_SIG;
            cil_pkg::PH_STOP:   end_st = stop_reg;
            cil_pkg::PH_CHIP:   end_st = (idx_reg != 4'd0) ? cil_pkg::ST_REJECT : cil_pkg::ST_OK;
            cil_pkg::PH_DATA:
                end_st = (split_now && done >= 16'h2000) ? cil_pkg::ST_OK : cil_pkg::ST_REJECT;
            default:            end_st = cil_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hlen_next  = hlen_reg;
        class_next = class_reg;
        exrom_next = exrom_reg;
        game_next  = game_reg;
        idx_next   = idx_reg;
        bank_next  = bank_reg;
        load_next  = load_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        waddr_next = waddr_reg;
        total_next = total_reg;
        upper_next = upper_reg;
        stop_next  = stop_reg;
        emit       = 1'b0;
        out_word   = '0;

        if (step && in_word.end_of_file)
        begin
            emit = 1'b1;
            out_word.kind = 1'b1;
            out_word.cart_code = code;
            out_word.status = end_st;
            phase_next = cil_pkg::PH_HEADER;
            pos_next   = '0;
            hlen_next  = '0;
            class_next = '0;
            exrom_next = '0;
            game_next  = '0;
            idx_next   = '0;
            bank_next  = '0;
            load_next  = '0;
            size_next  = '0;
            left_next  = '0;
            waddr_next = '0;
            total_next = '0;
            upper_next = 1'b0;
            stop_next  = '0;
        end
        else if (step)
        begin
            if (pos_reg != 32'hFFFF_FFFF)
                pos_next = pos_reg + 32'd1;
            case (phase_reg)
                cil_pkg::PH_HEADER:
                begin
                    if (pos_reg < 32'd16)
                    begin
                        if (b != cil_pkg::sig_char(pos_reg[3:0]))
                        begin
                            stop_next = cil_pkg::ST_BAD_SIG;
                            phase_next = cil_pkg::PH_STOP;
                        end
                    end
                    else if (pos_reg <= 32'h13)
                        hlen_next = {hlen_reg[23:0], b};
                    else if (pos_reg == 32'h16)
                    begin
                        if (b != 8'd0)
                        begin
                            stop_next = cil_pkg::ST_BAD_SIG;
                            phase_next = cil_pkg::PH_STOP;
                        end
                    end
                    else if (pos_reg == 32'h17)
                    begin
                        if (tclass == cil_pkg::CL_NONE)
                        begin
                            stop_next = cil_pkg::ST_UNKNOWN;
                            phase_next = cil_pkg::PH_STOP;
                        end
                        else if (tclass == cil_pkg::CL_NI)
                        begin
                            stop_next = cil_pkg::ST_NOT_IMPL;
                            phase_next = cil_pkg::PH_STOP;
                        end
                        else
                            class_next = tclass;
                    end
                    else if (pos_reg == 32'h18)
                        exrom_next = b;
                    else if (pos_reg == 32'h19)
                        game_next = b;
                    else if (pos_reg == 32'h1F)
                    begin
                        hlen_next = hlen_fix;
                        phase_next = (hlen_fix > 32'h20) ? cil_pkg::PH_SKIP : cil_pkg::PH_CHIP;
                    end
                end
                cil_pkg::PH_SKIP:
                begin
                    if (pos_next >= hlen_reg)
                        phase_next = cil_pkg::PH_CHIP;
                end
                cil_pkg::PH_CHIP:
                begin
                    if (idx_reg < 4'd4 && b != cil_pkg::tag_char(idx_reg[1:0]))
                    begin
                        idx_next = '0;
                        stop_next = cil_pkg::ST_REJECT;
                        phase_next = cil_pkg::PH_STOP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                        case (idx_reg)
                            4'd10, 4'd11: bank_next = {bank_reg[7:0], b};
                            4'd12, 4'd13: load_next = {load_reg[7:0], b};
                            4'd14:        size_next = {size_reg[7:0], b};
                            4'd15:
                            begin
                                size_next = size_full;
                                if (bank_reg > 16'h3F)
                                begin
                                    stop_next = cil_pkg::ST_REJECT;
                                    phase_next = cil_pkg::PH_STOP;
                                end
                                else
                                begin
                                    bank_next = bank_fix;
                                    waddr_next = base_addr;
                                    if (class_reg != cil_pkg::CL_KCS && load_reg == 16'hA000)
                                        upper_next = 1'b1;
                                    left_next = size_full;
                                    phase_next = (size_full != 16'd0) ? cil_pkg::PH_DATA
                                                                      : cil_pkg::PH_CHIP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                cil_pkg::PH_DATA:
                begin
                    emit = 1'b1;
                    out_word.address = OUT_ADDR'(waddr_reg);
                    out_word.data = b;
                    if (total_reg != 24'hFF_FFFF)
                        total_next = total_reg + 24'd1;
                    waddr_next = waddr_reg + ADDRESS_BITS'(1);
                    if (split_now && done == 16'h1FFF)
                        waddr_next = waddr_reg + ADDRESS_BITS'(1) + SPLIT_STEP;
                    left_next = left_reg - 16'd1;
                    if (left_reg == 16'd1)
                        phase_next = cil_pkg::PH_CHIP;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cil_pkg::PH_HEADER;
            pos_reg   <= '0;
            hlen_reg  <= '0;
            class_reg <= '0;
            exrom_reg <= '0;
            game_reg  <= '0;
            idx_reg   <= '0;
            bank_reg  <= '0;
            load_reg  <= '0;
            size_reg  <= '0;
            left_reg  <= '0;
            waddr_reg <= '0;
            total_reg <= '0;
            upper_reg <= 1'b0;
            stop_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hlen_reg  <= hlen_next;
            class_reg <= class_next;
            exrom_reg <= exrom_next;
            game_reg  <= game_next;
            idx_reg   <= idx_next;
            bank_reg  <= bank_next;
            load_reg  <= load_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            waddr_reg <= waddr_next;
            total_reg <= total_next;
            upper_reg <= upper_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

/* sv/cartridge_image_loader.sv */
// Channel  | Direction | Handshake    | Payload
// in       | into      | valid, stall | cil_pkg::in_word_t (end_of_file, data_byte)
// out      | out of    | valid, stall | cil_pkg::out_word_t (kind, address, data, ...)
// One word is accepted per cycle while in_stall is low; any result it produces is registered in the output register.
// The parser state updates in the same cycle the word is taken, so the rate is one word
// per cycle, limited only by the output register being free or being drained.
// Reset returns the parser to the start of a file header; no clearing pass is needed.
// A stalled output holds its word; input stalls only while that word is held.
module cartridge_image_loader #(
    parameter int ADDRESS_BITS = cil_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cil_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cil_pkg::out_word_t out_data
);

    logic               out_valid_reg, out_valid_next;
    cil_pkg::out_word_t out_data_reg;
    logic               step;
    logic               emit;
    cil_pkg::out_word_t word;

    assign in_stall = out_valid_reg && out_stall;
    assign step = in_valid && !in_stall;

    cil_parser #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_word  (in_data),
        .emit     (emit),
        .out_word (word)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (step)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            out_data_reg <= word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sim/cartridge_image_loader_test.sv */
`timescale 1ns / 100ps

module cartridge_image_loader_test;

    localparam int ABITS = 23;
    localparam logic [31:0] AMASK = (ABITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ABITS) - 1);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    cil_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_stall;
    cil_pkg::out_word_t out_data;

    cartridge_image_loader #(.ADDRESS_BITS(ABITS)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Parser shadow state.
    cil_pkg::phase_t ph;
    logic [31:0]  fpos;
    logic [31:0]  hlen;
    logic [4:0]   lclass;
    logic [7:0]   exrom_b;
    logic [7:0]   game_b;
    logic [3:0]   pidx;
    logic [15:0]  pbank;
    logic [15:0]  pload;
    logic [15:0]  psize;
    logic [15:0]  remaining;
    logic [31:0]  waddr;
    logic [23:0]  loaded;
    logic         upper_seen;
    logic [2:0]   halt_code;

    cil_pkg::out_word_t pending_words[$];
    int        errors;
    int        summaries;
    int        quiet_cycles;
    logic      drain_hold;
    logic      no_idle;

    typedef struct {
        int         count;
        logic [4:0] code;
        logic [2:0] status;
    } file_end_row_t;

    file_end_row_t end_rows[$];

    // One directed file: cut < 0 sends a full header, otherwise only that many
    // signature bytes. Rows with known set carry a typed-in file end word.
    typedef struct {
        int          cut;
        logic [7:0]  htype;
        logic [31:0] len;
        logic [7:0]  ex;
        logic [7:0]  gm;
        int          hflaw;
        int          packets;
        logic [15:0] bank;
        logic [15:0] load;
        logic [15:0] size;
        int          send;
        int          pflaw;
        logic        known;
        logic [4:0]  code;
        logic [2:0]  status;
    } file_row_t;

    file_row_t dir_rows[11] = '{
        '{0, 8'd0, 32'h0, 8'd0, 8'd0, 0, 0, 16'h0, 16'h0, 16'h0, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_BAD_SIG},
        '{-1, 8'd0, 32'h40, 8'd0, 8'd0, 2, 0, 16'h0, 16'h0, 16'h0, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_BAD_SIG},
        '{-1, 8'd255, 32'h40, 8'd0, 8'd0, 0, 0, 16'h0, 16'h0, 16'h0, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_UNKNOWN},
        '{-1, 8'd6, 32'h40, 8'd0, 8'd0, 0, 0, 16'h0, 16'h0, 16'h0, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_NOT_IMPL},
        '{-1, 8'd0, 32'h0, 8'd1, 8'd1, 0, 1, 16'h0000, 16'h8000, 16'h0003, 3, 0,
          1'b0, 5'd0, cil_pkg::ST_OK},
        '{-1, 8'd2, 32'h0, 8'd0, 8'd0, 0, 1, 16'h0001, 16'hFFFF, 16'hFFFF, 2, 0,
          1'b0, 5'd0, cil_pkg::ST_OK},
        '{-1, 8'd5, 32'hFFFF_FFFF, 8'd0, 8'd0, 0, 1, 16'h0010, 16'hA000, 16'h4000, 40, 0,
          1'b0, 5'd0, cil_pkg::ST_OK},
        '{-1, 8'd5, 32'h40, 8'd0, 8'd0, 0, 1, 16'h0010, 16'hA000, 16'h4000, 40, 0,
          1'b0, 5'd0, cil_pkg::ST_OK},
        '{-1, 8'd32, 32'h40, 8'd0, 8'd0, 0, 1, 16'hFFFF, 16'h8000, 16'h0001, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_REJECT},
        '{-1, 8'd0, 32'h20, 8'd0, 8'd1, 0, 1, 16'h0000, 16'h8000, 16'h0001, 0, 1,
          1'b1, 5'd0, cil_pkg::ST_REJECT},
        '{1, 8'd0, 32'h0, 8'd0, 8'd0, 0, 0, 16'h0, 16'h0, 16'h0, 0, 0,
          1'b1, 5'd0, cil_pkg::ST_BAD_SIG}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("cartridge_image_loader_test: done, errors");
        $finish;
    end

    function automatic logic [4:0] class_of_type(input logic [7:0] t);
        logic [4:0] c;
        case (t)
            8'd0:  c = cil_pkg::CL_NORMAL;
            8'd1:  c = cil_pkg::CL_ACTION;
            8'd2:  c = cil_pkg::CL_KCS;
            8'd3:  c = cil_pkg::CL_FINAL3;
            8'd4:  c = cil_pkg::CL_SBASIC;
            8'd5:  c = cil_pkg::CL_OCEAN;
            8'd9, 8'd36: c = cil_pkg::CL_RETRO;
            8'd10: c = cil_pkg::CL_EPYX;
            8'd11: c = cil_pkg::CL_WESTERMANN;
            8'd13: c = cil_pkg::CL_FINAL12;
            8'd15: c = cil_pkg::CL_SYSTEM3;
            8'd19: c = cil_pkg::CL_DOMARK;
            8'd20: c = cil_pkg::CL_SUPERSNAP;
            8'd21: c = cil_pkg::CL_COMAL80;
            8'd32: c = cil_pkg::CL_EASYFLASH;
            8'd54: c = cil_pkg::CL_BBASIC;
            default: c = ((t >= 8'd22 && t <= 8'd31) || t >= 8'd61) ? cil_pkg::CL_NONE
                                                                   : cil_pkg::CL_NI;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] signature_at(input int i);
        string s;
        s = "C64 CARTRIDGE   ";
        return s[i];
    endfunction

    function automatic logic [7:0] chip_tag_at(input int i);
        string s;
        s = "CHIP";
        return s[i];
    endfunction

    function automatic logic packet_is_split();
        return psize > 16'h2000 && (lclass == cil_pkg::CL_OCEAN
            || lclass == cil_pkg::CL_EASYFLASH || lclass == cil_pkg::CL_DOMARK
            || lclass == cil_pkg::CL_SYSTEM3);
    endfunction

    function automatic logic [4:0] mode_code();
        if (loaded == 0)
            return 5'd0;
        case (lclass)
            cil_pkg::CL_NORMAL:
            begin
                if (exrom_b == 0 && game_b == 1) return 5'h03;
                if (exrom_b == 1 && game_b == 1) return 5'h02;
                if (exrom_b == 1 && game_b == 0) return 5'h01;
                return (loaded > 8192) ? 5'h02 : 5'h01;
            end
            cil_pkg::CL_ACTION:     return 5'h07;
            cil_pkg::CL_RETRO:      return 5'h06;
            cil_pkg::CL_DOMARK:     return 5'h09;
            cil_pkg::CL_OCEAN:      return upper_seen ? 5'h0B : 5'h0A;
            cil_pkg::CL_EASYFLASH:  return 5'h0C;
            cil_pkg::CL_SUPERSNAP:  return 5'h05;
            cil_pkg::CL_EPYX:       return 5'h0E;
            cil_pkg::CL_FINAL3:     return 5'h04;
            cil_pkg::CL_SYSTEM3:    return 5'h08;
            cil_pkg::CL_COMAL80:    return 5'h0F;
            cil_pkg::CL_SBASIC:     return 5'h10;
            cil_pkg::CL_WESTERMANN: return 5'h11;
            cil_pkg::CL_KCS:        return 5'h13;
            cil_pkg::CL_FINAL12:    return 5'h14;
            cil_pkg::CL_BBASIC:     return 5'h15;
            default:                return 5'd0;
        endcase
    endfunction

    function automatic logic [2:0] file_end_status();
        logic [15:0] done;
        done = psize - remaining;
        case (ph)
            cil_pkg::PH_HEADER: return cil_pkg::ST_BAD_SIG;
            cil_pkg::PH_STOP:   return halt_code;
            cil_pkg::PH_CHIP:   return (pidx != 0) ? cil_pkg::ST_REJECT : cil_pkg::ST_OK;
            cil_pkg::PH_DATA:
                return (packet_is_split() && done >= 16'h2000) ? cil_pkg::ST_OK
                                                               : cil_pkg::ST_REJECT;
            default:            return cil_pkg::ST_OK;
        endcase
    endfunction

    task automatic clear_parser();
        ph = cil_pkg::PH_HEADER;
        fpos = 0; hlen = 0; lclass = cil_pkg::CL_NONE; exrom_b = 0; game_b = 0;
        pidx = 0; pbank = 0; pload = 0; psize = 0; remaining = 0;
        waddr = 0; loaded = 0; upper_seen = 0; halt_code = cil_pkg::ST_OK;
    endtask

    task automatic stop_parse(input logic [2:0] s);
        halt_code = s;
        ph = cil_pkg::PH_STOP;
    endtask

    task automatic close_packet();
        logic [63:0] a;
        if (pbank > 16'h3F)
        begin
            stop_parse(cil_pkg::ST_REJECT);
            return;
        end
        if (lclass == cil_pkg::CL_OCEAN && pload == 16'hA000)
            pbank = pbank & 16'hEF;
        if (lclass == cil_pkg::CL_KCS)
            a = 64'(pload) + 64'h1_0000_0000 - 64'h8000;
        else
        begin
            a = packet_is_split() ? 64'h2000 * pbank : 64'(psize) * pbank;
            if (pload == 16'hA000)
            begin
                a += 512 * 1024;
                upper_seen = 1'b1;
            end
        end
        waddr = a[31:0] & AMASK;
        remaining = psize;
        ph = (psize != 0) ? cil_pkg::PH_DATA : cil_pkg::PH_CHIP;
    endtask

    // Advances the shadow parser by one accepted word and queues what it produces.
    task automatic parse_word(input cil_pkg::in_word_t w);
        logic [31:0] pos;
        logic [7:0]  b;
        logic [4:0]  c;
        logic [15:0] done;
        cil_pkg::out_word_t r;
        b = w.data_byte;
        pos = fpos;
        if (w.end_of_file)
        begin
            r = '0;
            r.kind = 1'b1;
            r.cart_code = mode_code();
            r.status = file_end_status();
            pending_words.push_back(r);
            clear_parser();
            return;
        end
        if (fpos != 32'hFFFF_FFFF)
            fpos++;
        case (ph)
            cil_pkg::PH_HEADER:
            begin
                if (pos < 16)
                begin
                    if (b != signature_at(pos)) stop_parse(cil_pkg::ST_BAD_SIG);
                end
                else if (pos <= 32'h13)
                    hlen = {hlen[23:0], b};
                else if (pos == 32'h16)
                begin
                    if (b != 0) stop_parse(cil_pkg::ST_BAD_SIG);
                end
                else if (pos == 32'h17)
                begin
                    c = class_of_type(b);
                    if (c == cil_pkg::CL_NONE) stop_parse(cil_pkg::ST_UNKNOWN);
                    else if (c == cil_pkg::CL_NI) stop_parse(cil_pkg::ST_NOT_IMPL);
                    else lclass = c;
                end
                else if (pos == 32'h18)
                    exrom_b = b;
                else if (pos == 32'h19)
                    game_b = b;
                if (ph == cil_pkg::PH_HEADER && pos == 32'h1F)
                begin
                    if (lclass == cil_pkg::CL_KCS) hlen = 32'h40;
                    if (hlen < 32'h20) hlen = 32'h20;
                    ph = (hlen > 32'h20) ? cil_pkg::PH_SKIP : cil_pkg::PH_CHIP;
                end
            end
            cil_pkg::PH_SKIP:
                if (fpos >= hlen) ph = cil_pkg::PH_CHIP;
            cil_pkg::PH_CHIP:
            begin
                if (pidx < 4 && b != chip_tag_at(pidx))
                begin
                    pidx = 0;
                    stop_parse(cil_pkg::ST_REJECT);
                end
                else
                begin
                    if (pidx == 10 || pidx == 11) pbank = {pbank[7:0], b};
                    else if (pidx == 12 || pidx == 13) pload = {pload[7:0], b};
                    else if (pidx == 14 || pidx == 15) psize = {psize[7:0], b};
                    if (pidx == 15)
                    begin
                        pidx = 0;
                        close_packet();
                    end
                    else
                        pidx++;
                end
            end
            cil_pkg::PH_DATA:
            begin
                done = psize - remaining;
                r = '0;
                r.address = waddr[22:0];
                r.data = b;
                pending_words.push_back(r);
                if (loaded != 24'hFF_FFFF) loaded++;
                waddr = (waddr + 1) & AMASK;
                // The second half of a split packet goes to the upper 512K.
                if (packet_is_split() && done == 16'h1FFF)
                    waddr = (waddr + 32'd524288 - 32'h2000) & AMASK;
                remaining--;
                if (remaining == 0) ph = cil_pkg::PH_CHIP;
            end
            default: ;
        endcase
    endtask

    // Result checking.
    always @(posedge clk)
    begin
        cil_pkg::out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (out_data.kind !== e.kind || out_data.address !== e.address
                    || out_data.data !== e.data || out_data.cart_code !== e.cart_code
                    || out_data.status !== e.status)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
                    errors++;
                end
            end
            if (out_data.kind === 1'b1)
            begin
                if (end_rows.size() != 0 && end_rows[0].count == summaries)
                begin
                    if (out_data.cart_code !== end_rows[0].code
                        || out_data.status !== end_rows[0].status)
                    begin
                        $display("%0t: file end %0d, expected code %0d status %0d, actual code %0d status %0d",
                                 $time, summaries, end_rows[0].code, end_rows[0].status,
                                 out_data.cart_code, out_data.status);
                        errors++;
                    end
                    void'(end_rows.pop_front());
                end
                summaries++;
            end
        end
    end

    // Receiver stall, with one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (drain_hold)
            begin
                quiet_cycles++;
                out_stall <= (quiet_cycles < 200);
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 18);
        end
    end

    cil_pkg::in_word_t stim[$];

    task automatic add_byte(input logic [7:0] b);
        cil_pkg::in_word_t w;
        w.end_of_file = 1'b0;
        w.data_byte = b;
        stim.push_back(w);
    endtask

    task automatic add_eof();
        cil_pkg::in_word_t w;
        w.end_of_file = 1'b1;
        w.data_byte = 8'($urandom);
        stim.push_back(w);
    endtask

    // Builds a header; flaw selects an optional corruption.
    task automatic add_header(input logic [7:0] htype, input logic [31:0] len,
                              input logic [7:0] ex, input logic [7:0] gm, input int flaw);
        for (int i = 0; i < 16; i++)
            add_byte((flaw == 1 && i == 5) ? 8'h00 : signature_at(i));
        for (int i = 3; i >= 0; i--) add_byte(len[i*8 +: 8]);
        add_byte(8'($urandom)); add_byte(8'($urandom));
        add_byte(flaw == 2 ? 8'h01 : 8'h00);
        add_byte(htype); add_byte(ex); add_byte(gm);
        for (int i = 26; i < 32; i++) add_byte(8'($urandom));
        // Skip region up to the stated header length (0x40 for KCS), sent at most to byte 96.
        if (htype == 8'd2) len = 32'h40;
        for (int i = 32; i < len && i < 96; i++) add_byte(8'($urandom));
    endtask

    task automatic add_packet(input logic [15:0] bank, input logic [15:0] load,
                              input logic [15:0] size, input int send, input int flaw);
        for (int i = 0; i < 4; i++)
            add_byte((flaw == 1 && i == 2) ? 8'h58 : chip_tag_at(i));
        for (int i = 4; i < 10; i++) add_byte(8'($urandom));
        add_byte(bank[15:8]); add_byte(bank[7:0]);
        add_byte(load[15:8]); add_byte(load[7:0]);
        add_byte(size[15:8]); add_byte(size[7:0]);
        for (int i = 0; i < send; i++) add_byte(8'($urandom));
    endtask

    task automatic random_file();
        int types[] = '{0, 1, 2, 3, 4, 5, 9, 10, 11, 13, 15, 19, 20, 21, 32, 36, 54};
        logic [7:0] t;
        logic [15:0] sz, ld;
        int r, np;
        r = $urandom_range(99);
        t = (r < 85) ? 8'(types[$urandom_range(types.size() - 1)]) : 8'($urandom);
        add_header(t, (r % 3 == 0) ? 32'($urandom_range(0, 'h50)) : 32'h40,
                   8'($urandom_range(2)), 8'($urandom_range(2)), (r > 96) ? r - 96 : 0);
        np = $urandom_range(3);
        for (int p = 0; p < np; p++)
        begin
            sz = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
            ld = ($urandom_range(1)) ? 16'hA000 : 16'($urandom);
            add_packet(($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(63)),
                       ld, sz, (sz > 16'd40) ? int'($urandom_range(40)) : int'(sz),
                       $urandom_range(29) == 0);
        end
        if ($urandom_range(9) == 0)
            for (int i = 0; i < 10; i++) add_byte(8'($urandom));
        add_eof();
    endtask

    initial
    begin
        file_end_row_t er;
        errors = 0;
        summaries = 0;
        quiet_cycles = 0;
        drain_hold = 1'b0;
        no_idle = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        clear_parser();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed files: end right after reset, nonzero byte 0x16, unknown type, not
        // implemented, normal 16K, KCS, Ocean with an endless skip, Ocean split at
        // A000, big bank, bad chip tag, end inside the signature.
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].cut >= 0)
            begin
                for (int i = 0; i < dir_rows[k].cut; i++) add_byte(signature_at(i));
            end
            else
                add_header(dir_rows[k].htype, dir_rows[k].len, dir_rows[k].ex,
                           dir_rows[k].gm, dir_rows[k].hflaw);
            for (int p = 0; p < dir_rows[k].packets; p++)
                add_packet(dir_rows[k].bank, dir_rows[k].load, dir_rows[k].size,
                           dir_rows[k].send, dir_rows[k].pflaw);
            add_eof();
            if (dir_rows[k].known)
            begin
                er.count = k;
                er.code = dir_rows[k].code;
                er.status = dir_rows[k].status;
                end_rows.push_back(er);
            end
        end

        for (int i = 0; i < stim.size(); i++)
        begin
            in_valid <= !no_idle && ($urandom_range(99) < 18) ? 1'b0 : 1'b1;
            in_data <= stim[i];
            @(posedge clk);
            while (!(in_valid && !in_stall))
            begin
                @(negedge clk);
                in_valid <= 1'b1;
                @(posedge clk);
            end
            parse_word(stim[i]);
            @(negedge clk);
            // Long receiver hold-off while the sender keeps going.
            if (i == 40) drain_hold = 1'b1;
            if (i == 300) drain_hold = 1'b0;
            if (i == 600) no_idle = 1'b1;
            if (i == 900) no_idle = 1'b0;
            if (i == 1000)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending_words.size() != 0) @(negedge clk);
            end
            if (i == stim.size() - 1 && i < 1400)
                random_file();
        end
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("cartridge_image_loader_test: done, clean");
        else
            $display("cartridge_image_loader_test: done, errors");
        $finish;
    end

endmodule
